@@ design/mmi_pkg.sv @@
// ----------------------------------------------------------------------------
// mmi_pkg
// Shared types, register codes, widths and constants for the monoclinic
// minimum image pipeline.
// ----------------------------------------------------------------------------
package mmi_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 32;
	localparam int CELL_W          = 31;
	localparam int INV_W           = 32;
	localparam int DIST_W          = 63;
	localparam int FRAC_MAX_W      = 63;
	localparam int FRAC_SHIFT      = 16;
	localparam int BACK_SHIFT      = 30;
	localparam int FRAC_HALF       = 1 << 29;
	localparam int FRAC_ONE        = 1 << 30;
	localparam int LATENCY         = 10;

	localparam logic [CFG_IDX_W-1:0] REG_CELL_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_CX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_CZ = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_XX = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INV_YY = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INV_XZ = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_INV_ZZ = 3'd7;

	localparam logic [CELL_W-1:0]       CELL_ONE = 31'd65536;
	localparam logic signed [INV_W-1:0] INV_ONE  = 32'sd1073741824;

	typedef struct packed {
		logic [CELL_W-1:0]       a_len;
		logic [CELL_W-1:0]       b_len;
		logic signed [INV_W-1:0] c_x;
		logic [CELL_W-1:0]       c_z;
		logic signed [INV_W-1:0] inv_xx;
		logic signed [INV_W-1:0] inv_yy;
		logic signed [INV_W-1:0] inv_xz;
		logic signed [INV_W-1:0] inv_zz;
	} cell_cfg_t;

	// width of a fractional coordinate in Q.30
	function automatic int frac_width(input int cw);
		return (cw + 18 > FRAC_MAX_W) ? FRAC_MAX_W : cw + 18;
	endfunction

endpackage

@@ design/mmi_cfg.sv @@
// ----------------------------------------------------------------------------
// mmi_cfg
// Cell matrix and inverse matrix register file.
// ----------------------------------------------------------------------------
module mmi_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [mmi_pkg::CFG_IDX_W-1:0]    wr_idx,
	input  logic [mmi_pkg::CFG_DATA_W-1:0]   wr_data,
	output mmi_pkg::cell_cfg_t               cell_cfg
);
	import mmi_pkg::*;

	cell_cfg_t cell_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q.a_len  <= CELL_ONE;
			cell_q.b_len  <= CELL_ONE;
			cell_q.c_x    <= '0;
			cell_q.c_z    <= CELL_ONE;
			cell_q.inv_xx <= INV_ONE;
			cell_q.inv_yy <= INV_ONE;
			cell_q.inv_xz <= '0;
			cell_q.inv_zz <= INV_ONE;
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_CELL_A:  cell_q.a_len  <= wr_data[CELL_W-1:0];
				REG_CELL_B:  cell_q.b_len  <= wr_data[CELL_W-1:0];
				REG_CELL_CX: cell_q.c_x    <= wr_data[INV_W-1:0];
				REG_CELL_CZ: cell_q.c_z    <= wr_data[CELL_W-1:0];
				REG_INV_XX:  cell_q.inv_xx <= wr_data[INV_W-1:0];
				REG_INV_YY:  cell_q.inv_yy <= wr_data[INV_W-1:0];
				REG_INV_XZ:  cell_q.inv_xz <= wr_data[INV_W-1:0];
				REG_INV_ZZ:  cell_q.inv_zz <= wr_data[INV_W-1:0];
			endcase
		end
	end

	assign cell_cfg = cell_q;

endmodule

@@ design/mmi_frac.sv @@
// ----------------------------------------------------------------------------
// mmi_frac
// Stages 1 to 4: position difference, inverse matrix products, Q.30
// fraction with saturation, and the half-cell wrap.
// ----------------------------------------------------------------------------
module mmi_frac #(
	parameter int COORD_WIDTH = mmi_pkg::COORD_WIDTH_DEF
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  in_vld,
	input  logic signed [COORD_WIDTH-1:0]                         p1_x,
	input  logic signed [COORD_WIDTH-1:0]                         p1_y,
	input  logic signed [COORD_WIDTH-1:0]                         p1_z,
	input  logic signed [COORD_WIDTH-1:0]                         p2_x,
	input  logic signed [COORD_WIDTH-1:0]                         p2_y,
	input  logic signed [COORD_WIDTH-1:0]                         p2_z,
	input  mmi_pkg::cell_cfg_t                                    cell_cfg,
	output logic                                                  out_vld,
	output logic signed [mmi_pkg::frac_width(COORD_WIDTH)-1:0]    f_x,
	output logic signed [mmi_pkg::frac_width(COORD_WIDTH)-1:0]    f_y,
	output logic signed [mmi_pkg::frac_width(COORD_WIDTH)-1:0]    f_z,
	output logic signed [COORD_WIDTH-1:0]                         p2d_x,
	output logic signed [COORD_WIDTH-1:0]                         p2d_y,
	output logic signed [COORD_WIDTH-1:0]                         p2d_z
);
	import mmi_pkg::*;

	localparam int CW  = COORD_WIDTH;
	localparam int DW  = CW + 1;
	localparam int DL  = DW / 2;
	localparam int DH  = DW - DL;
	localparam int LPW = INV_W + DL + 1;
	localparam int HPW = INV_W + DH;
	localparam int SW  = CW + 35;
	localparam int FRW = SW - FRAC_SHIFT;
	localparam int FW  = frac_width(CW);

	localparam logic signed [FRW-1:0] F_MAX = {{(FRW-FW+1){1'b0}}, {(FW-1){1'b1}}};
	localparam logic signed [FRW-1:0] F_MIN = {{(FRW-FW+1){1'b1}}, {(FW-1){1'b0}}};
	localparam logic signed [FW-1:0]  HALF_F = FW'(FRAC_HALF);
	localparam logic signed [FW-1:0]  ONE_F  = FW'(FRAC_ONE);

	logic                   vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [DW-1:0]   dx_s1, dy_s1, dz_s1;
	logic signed [CW-1:0]   px_s1, py_s1, pz_s1;
	logic signed [CW-1:0]   px_s2, py_s2, pz_s2;
	logic signed [CW-1:0]   px_s3, py_s3, pz_s3;
	logic signed [CW-1:0]   px_s4, py_s4, pz_s4;
	logic signed [DL:0]     dxl, dyl, dzl;
	logic signed [DH-1:0]   dxh, dyh, dzh;
	logic signed [LPW-1:0]  xx_l_s2, xz_l_s2, yy_l_s2, zz_l_s2;
	logic signed [HPW-1:0]  xx_h_s2, xz_h_s2, yy_h_s2, zz_h_s2;
	logic signed [SW-1:0]   sum_x, sum_y, sum_z;
	logic signed [FRW-1:0]  fx_s3, fy_s3, fz_s3;
	logic signed [FW-1:0]   fx_s4, fy_s4, fz_s4;

	function automatic logic signed [FW-1:0] sat_wrap(input logic signed [FRW-1:0] v);
		logic signed [FW-1:0] s;
		priority if (v > F_MAX) begin
			s = F_MAX[FW-1:0];
		end else if (v < F_MIN) begin
			s = F_MIN[FW-1:0];
		end else begin
			s = v[FW-1:0];
		end
		priority if (s < -HALF_F) begin
			return s + ONE_F;
		end else if (s > HALF_F) begin
			return s - ONE_F;
		end else begin
			return s;
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// stage 1: difference
	always_ff @(posedge clk) begin
		dx_s1 <= DW'(p2_x) - DW'(p1_x);
		dy_s1 <= DW'(p2_y) - DW'(p1_y);
		dz_s1 <= DW'(p2_z) - DW'(p1_z);
		px_s1 <= p2_x;
		py_s1 <= p2_y;
		pz_s1 <= p2_z;
	end

	// split differences into an unsigned low half and a signed high half
	assign dxl = {1'b0, dx_s1[DL-1:0]};
	assign dyl = {1'b0, dy_s1[DL-1:0]};
	assign dzl = {1'b0, dz_s1[DL-1:0]};
	assign dxh = dx_s1[DW-1:DL];
	assign dyh = dy_s1[DW-1:DL];
	assign dzh = dz_s1[DW-1:DL];

	// stage 2: partial products
	always_ff @(posedge clk) begin
		xx_l_s2 <= cell_cfg.inv_xx * dxl;
		xx_h_s2 <= cell_cfg.inv_xx * dxh;
		xz_l_s2 <= cell_cfg.inv_xz * dzl;
		xz_h_s2 <= cell_cfg.inv_xz * dzh;
		yy_l_s2 <= cell_cfg.inv_yy * dyl;
		yy_h_s2 <= cell_cfg.inv_yy * dyh;
		zz_l_s2 <= cell_cfg.inv_zz * dzl;
		zz_h_s2 <= cell_cfg.inv_zz * dzh;
		px_s2   <= px_s1;
		py_s2   <= py_s1;
		pz_s2   <= pz_s1;
	end

	assign sum_x = (SW'(xx_h_s2) <<< DL) + SW'(xx_l_s2)
		+ (SW'(xz_h_s2) <<< DL) + SW'(xz_l_s2);
	assign sum_y = (SW'(yy_h_s2) <<< DL) + SW'(yy_l_s2);
	assign sum_z = (SW'(zz_h_s2) <<< DL) + SW'(zz_l_s2);

	// stage 3: sum and floor shift to Q.30
	always_ff @(posedge clk) begin
		fx_s3 <= sum_x[SW-1:FRAC_SHIFT];
		fy_s3 <= sum_y[SW-1:FRAC_SHIFT];
		fz_s3 <= sum_z[SW-1:FRAC_SHIFT];
		px_s3 <= px_s2;
		py_s3 <= py_s2;
		pz_s3 <= pz_s2;
	end

	// stage 4: saturate and wrap into the central cell
	always_ff @(posedge clk) begin
		fx_s4 <= sat_wrap(fx_s3);
		fy_s4 <= sat_wrap(fy_s3);
		fz_s4 <= sat_wrap(fz_s3);
		px_s4 <= px_s3;
		py_s4 <= py_s3;
		pz_s4 <= pz_s3;
	end

	assign out_vld = vld_s4;
	assign f_x     = fx_s4;
	assign f_y     = fy_s4;
	assign f_z     = fz_s4;
	assign p2d_x   = px_s4;
	assign p2d_y   = py_s4;
	assign p2d_z   = pz_s4;

endmodule

@@ design/mmi_back.sv @@
// ----------------------------------------------------------------------------
// mmi_back
// Stages 5 to 7: cell matrix products on the wrapped fraction, floor
// shift back to Q16.16 and saturation to the coordinate range.
// ----------------------------------------------------------------------------
module mmi_back #(
	parameter int COORD_WIDTH = mmi_pkg::COORD_WIDTH_DEF
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  in_vld,
	input  logic signed [mmi_pkg::frac_width(COORD_WIDTH)-1:0]    f_x,
	input  logic signed [mmi_pkg::frac_width(COORD_WIDTH)-1:0]    f_y,
	input  logic signed [mmi_pkg::frac_width(COORD_WIDTH)-1:0]    f_z,
	input  logic signed [COORD_WIDTH-1:0]                         p2_x,
	input  logic signed [COORD_WIDTH-1:0]                         p2_y,
	input  logic signed [COORD_WIDTH-1:0]                         p2_z,
	input  mmi_pkg::cell_cfg_t                                    cell_cfg,
	output logic                                                  out_vld,
	output logic signed [COORD_WIDTH-1:0]                         v_x,
	output logic signed [COORD_WIDTH-1:0]                         v_y,
	output logic signed [COORD_WIDTH-1:0]                         v_z,
	output logic signed [COORD_WIDTH-1:0]                         p2d_x,
	output logic signed [COORD_WIDTH-1:0]                         p2d_y,
	output logic signed [COORD_WIDTH-1:0]                         p2d_z
);
	import mmi_pkg::*;

	localparam int CW  = COORD_WIDTH;
	localparam int FW  = frac_width(CW);
	localparam int FL  = FW / 2;
	localparam int FH  = FW - FL;
	localparam int LPW = INV_W + FL + 1;
	localparam int HPW = INV_W + FH;
	localparam int BW  = INV_W + FW + 3;
	localparam int VRW = BW - BACK_SHIFT;

	localparam logic signed [VRW-1:0] V_MAX = {{(VRW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [VRW-1:0] V_MIN = {{(VRW-CW+1){1'b1}}, {(CW-1){1'b0}}};

	logic                    vld_s5, vld_s6, vld_s7;
	logic signed [INV_W-1:0] a_s, b_s, cz_s;
	logic signed [FL:0]      fxl, fyl, fzl;
	logic signed [FH-1:0]    fxh, fyh, fzh;
	logic signed [LPW-1:0]   ax_l_s5, cx_l_s5, by_l_s5, cz_l_s5;
	logic signed [HPW-1:0]   ax_h_s5, cx_h_s5, by_h_s5, cz_h_s5;
	logic signed [CW-1:0]    px_s5, py_s5, pz_s5;
	logic signed [CW-1:0]    px_s6, py_s6, pz_s6;
	logic signed [CW-1:0]    px_s7, py_s7, pz_s7;
	logic signed [BW-1:0]    sum_x, sum_y, sum_z;
	logic signed [VRW-1:0]   vx_s6, vy_s6, vz_s6;
	logic signed [CW-1:0]    vx_s7, vy_s7, vz_s7;

	function automatic logic signed [CW-1:0] sat_coord(input logic signed [VRW-1:0] v);
		priority if (v > V_MAX) begin
			return V_MAX[CW-1:0];
		end else if (v < V_MIN) begin
			return V_MIN[CW-1:0];
		end else begin
			return v[CW-1:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s5 <= in_vld;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	assign a_s  = {1'b0, cell_cfg.a_len};
	assign b_s  = {1'b0, cell_cfg.b_len};
	assign cz_s = {1'b0, cell_cfg.c_z};

	assign fxl = {1'b0, f_x[FL-1:0]};
	assign fyl = {1'b0, f_y[FL-1:0]};
	assign fzl = {1'b0, f_z[FL-1:0]};
	assign fxh = f_x[FW-1:FL];
	assign fyh = f_y[FW-1:FL];
	assign fzh = f_z[FW-1:FL];

	// stage 5: partial products
	always_ff @(posedge clk) begin
		ax_l_s5 <= a_s * fxl;
		ax_h_s5 <= a_s * fxh;
		cx_l_s5 <= cell_cfg.c_x * fzl;
		cx_h_s5 <= cell_cfg.c_x * fzh;
		by_l_s5 <= b_s * fyl;
		by_h_s5 <= b_s * fyh;
		cz_l_s5 <= cz_s * fzl;
		cz_h_s5 <= cz_s * fzh;
		px_s5   <= p2_x;
		py_s5   <= p2_y;
		pz_s5   <= p2_z;
	end

	assign sum_x = (BW'(ax_h_s5) <<< FL) + BW'(ax_l_s5)
		+ (BW'(cx_h_s5) <<< FL) + BW'(cx_l_s5);
	assign sum_y = (BW'(by_h_s5) <<< FL) + BW'(by_l_s5);
	assign sum_z = (BW'(cz_h_s5) <<< FL) + BW'(cz_l_s5);

	// stage 6: sum and floor shift to Q16.16
	always_ff @(posedge clk) begin
		vx_s6 <= sum_x[BW-1:BACK_SHIFT];
		vy_s6 <= sum_y[BW-1:BACK_SHIFT];
		vz_s6 <= sum_z[BW-1:BACK_SHIFT];
		px_s6 <= px_s5;
		py_s6 <= py_s5;
		pz_s6 <= pz_s5;
	end

	// stage 7: saturate to the coordinate range
	always_ff @(posedge clk) begin
		vx_s7 <= sat_coord(vx_s6);
		vy_s7 <= sat_coord(vy_s6);
		vz_s7 <= sat_coord(vz_s6);
		px_s7 <= px_s6;
		py_s7 <= py_s6;
		pz_s7 <= pz_s6;
	end

	assign out_vld = vld_s7;
	assign v_x     = vx_s7;
	assign v_y     = vy_s7;
	assign v_z     = vz_s7;
	assign p2d_x   = px_s7;
	assign p2d_y   = py_s7;
	assign p2d_z   = pz_s7;

endmodule

@@ design/mmi_out.sv @@
// ----------------------------------------------------------------------------
// mmi_out
// Stages 8 to 10: nearest image with saturation, squared length from
// split partial products, and the result registers.
// ----------------------------------------------------------------------------
module mmi_out #(
	parameter int COORD_WIDTH = mmi_pkg::COORD_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_vld,
	input  logic signed [COORD_WIDTH-1:0]     v_x,
	input  logic signed [COORD_WIDTH-1:0]     v_y,
	input  logic signed [COORD_WIDTH-1:0]     v_z,
	input  logic signed [COORD_WIDTH-1:0]     p2_x,
	input  logic signed [COORD_WIDTH-1:0]     p2_y,
	input  logic signed [COORD_WIDTH-1:0]     p2_z,
	output logic                              done,
	output logic signed [COORD_WIDTH-1:0]     vec_x,
	output logic signed [COORD_WIDTH-1:0]     vec_y,
	output logic signed [COORD_WIDTH-1:0]     vec_z,
	output logic signed [COORD_WIDTH-1:0]     img_x,
	output logic signed [COORD_WIDTH-1:0]     img_y,
	output logic signed [COORD_WIDTH-1:0]     img_z,
	output logic [mmi_pkg::DIST_W-1:0]        dist_sq
);
	import mmi_pkg::*;

	localparam int CW  = COORD_WIDTH;
	localparam int VL  = CW / 2;
	localparam int VH  = CW - VL;
	localparam int QW  = 2 * CW + 2;
	localparam int TW  = (2 * CW + 4 > DIST_W + 1) ? 2 * CW + 4 : DIST_W + 1;

	localparam logic signed [CW:0]   I_MAX = {2'b00, {(CW-1){1'b1}}};
	localparam logic signed [CW:0]   I_MIN = {2'b11, {(CW-1){1'b0}}};
	localparam logic signed [TW-1:0] D_MAX = {{(TW-DIST_W){1'b0}}, {DIST_W{1'b1}}};

	logic                        vld_s8, vld_s9, vld_s10;
	logic signed [VL:0]          vxl, vyl, vzl;
	logic signed [VH-1:0]        vxh, vyh, vzh;
	logic signed [CW:0]          ix_s8, iy_s8, iz_s8;
	logic signed [2*VH-1:0]      xhh_s8, yhh_s8, zhh_s8;
	logic signed [VH+VL:0]       xhl_s8, yhl_s8, zhl_s8;
	logic signed [2*VL+1:0]      xll_s8, yll_s8, zll_s8;
	logic signed [CW-1:0]        vx_s8, vy_s8, vz_s8;
	logic signed [CW-1:0]        vx_s9, vy_s9, vz_s9;
	logic signed [CW-1:0]        ix_s9, iy_s9, iz_s9;
	logic signed [QW-1:0]        sqx_s9, sqy_s9, sqz_s9;
	logic signed [TW-1:0]        total;
	logic signed [CW-1:0]        vx_s10, vy_s10, vz_s10;
	logic signed [CW-1:0]        ix_s10, iy_s10, iz_s10;
	logic [DIST_W-1:0]           dist_s10;

	function automatic logic signed [CW-1:0] sat_img(input logic signed [CW:0] s);
		priority if (s > I_MAX) begin
			return I_MAX[CW-1:0];
		end else if (s < I_MIN) begin
			return I_MIN[CW-1:0];
		end else begin
			return s[CW-1:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			vld_s8  <= in_vld;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	assign vxl = {1'b0, v_x[VL-1:0]};
	assign vyl = {1'b0, v_y[VL-1:0]};
	assign vzl = {1'b0, v_z[VL-1:0]};
	assign vxh = v_x[CW-1:VL];
	assign vyh = v_y[CW-1:VL];
	assign vzh = v_z[CW-1:VL];

	// stage 8: image sum and square partial products
	always_ff @(posedge clk) begin
		ix_s8  <= (CW+1)'(v_x) + (CW+1)'(p2_x);
		iy_s8  <= (CW+1)'(v_y) + (CW+1)'(p2_y);
		iz_s8  <= (CW+1)'(v_z) + (CW+1)'(p2_z);
		xhh_s8 <= vxh * vxh;
		yhh_s8 <= vyh * vyh;
		zhh_s8 <= vzh * vzh;
		xhl_s8 <= vxh * vxl;
		yhl_s8 <= vyh * vyl;
		zhl_s8 <= vzh * vzl;
		xll_s8 <= vxl * vxl;
		yll_s8 <= vyl * vyl;
		zll_s8 <= vzl * vzl;
		vx_s8  <= v_x;
		vy_s8  <= v_y;
		vz_s8  <= v_z;
	end

	// stage 9: per-axis squares and image saturation
	always_ff @(posedge clk) begin
		sqx_s9 <= (QW'(xhh_s8) <<< (2 * VL)) + (QW'(xhl_s8) <<< (VL + 1)) + QW'(xll_s8);
		sqy_s9 <= (QW'(yhh_s8) <<< (2 * VL)) + (QW'(yhl_s8) <<< (VL + 1)) + QW'(yll_s8);
		sqz_s9 <= (QW'(zhh_s8) <<< (2 * VL)) + (QW'(zhl_s8) <<< (VL + 1)) + QW'(zll_s8);
		ix_s9  <= sat_img(ix_s8);
		iy_s9  <= sat_img(iy_s8);
		iz_s9  <= sat_img(iz_s8);
		vx_s9  <= vx_s8;
		vy_s9  <= vy_s8;
		vz_s9  <= vz_s8;
	end

	assign total = TW'(sqx_s9) + TW'(sqy_s9) + TW'(sqz_s9);

	// stage 10: squared length with saturation, result registers
	always_ff @(posedge clk) begin
		dist_s10 <= (total > D_MAX) ? D_MAX[DIST_W-1:0] : total[DIST_W-1:0];
		vx_s10   <= vx_s9;
		vy_s10   <= vy_s9;
		vz_s10   <= vz_s9;
		ix_s10   <= ix_s9;
		iy_s10   <= iy_s9;
		iz_s10   <= iz_s9;
	end

	assign done    = vld_s10;
	assign vec_x   = vx_s10;
	assign vec_y   = vy_s10;
	assign vec_z   = vz_s10;
	assign img_x   = ix_s10;
	assign img_y   = iy_s10;
	assign img_z   = iz_s10;
	assign dist_sq = dist_s10;

endmodule

@@ design/monoclinic_minimum_image_top.sv @@
// ----------------------------------------------------------------------------
// monoclinic_minimum_image_top
// Minimum image vector, nearest image and squared length for a pair of
// positions in a monoclinic periodic cell.
// ----------------------------------------------------------------------------
// One pair is taken in every clock cycle; busy never rises. Each result
// appears on the result ports for one cycle with done high, after passing
// the ten register stages of the datapath (difference, three of split inverse
// products, sum and wrap, three of split cell products and saturation, three
// of image and squared length).
// Results cannot be held off, so the receiver must take every done cycle.
// Register writes are always taken and act at once on both product stages;
// change them only while no pair is in flight.
module monoclinic_minimum_image_top #(
	parameter int COORD_WIDTH = mmi_pkg::COORD_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [COORD_WIDTH-1:0]     p1_x,
	input  logic signed [COORD_WIDTH-1:0]     p1_y,
	input  logic signed [COORD_WIDTH-1:0]     p1_z,
	input  logic signed [COORD_WIDTH-1:0]     p2_x,
	input  logic signed [COORD_WIDTH-1:0]     p2_y,
	input  logic signed [COORD_WIDTH-1:0]     p2_z,
	output logic                              done,
	output logic signed [COORD_WIDTH-1:0]     vec_x,
	output logic signed [COORD_WIDTH-1:0]     vec_y,
	output logic signed [COORD_WIDTH-1:0]     vec_z,
	output logic signed [COORD_WIDTH-1:0]     img_x,
	output logic signed [COORD_WIDTH-1:0]     img_y,
	output logic signed [COORD_WIDTH-1:0]     img_z,
	output logic [mmi_pkg::DIST_W-1:0]        dist_sq,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mmi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mmi_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import mmi_pkg::*;

	localparam int FW = frac_width(COORD_WIDTH);

	cell_cfg_t                     cell_cfg;
	logic                          in_vld;
	logic                          frac_vld;
	logic                          back_vld;
	logic signed [FW-1:0]          f_x, f_y, f_z;
	logic signed [COORD_WIDTH-1:0] pa_x, pa_y, pa_z;
	logic signed [COORD_WIDTH-1:0] pb_x, pb_y, pb_z;
	logic signed [COORD_WIDTH-1:0] v_x, v_y, v_z;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign in_vld    = start && !busy;

	mmi_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_idx   (cfg_index),
		.wr_data  (cfg_data),
		.cell_cfg (cell_cfg)
	);

	mmi_frac #(.COORD_WIDTH(COORD_WIDTH)) u_frac (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (in_vld),
		.p1_x     (p1_x),
		.p1_y     (p1_y),
		.p1_z     (p1_z),
		.p2_x     (p2_x),
		.p2_y     (p2_y),
		.p2_z     (p2_z),
		.cell_cfg (cell_cfg),
		.out_vld  (frac_vld),
		.f_x      (f_x),
		.f_y      (f_y),
		.f_z      (f_z),
		.p2d_x    (pa_x),
		.p2d_y    (pa_y),
		.p2d_z    (pa_z)
	);

	mmi_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (frac_vld),
		.f_x      (f_x),
		.f_y      (f_y),
		.f_z      (f_z),
		.p2_x     (pa_x),
		.p2_y     (pa_y),
		.p2_z     (pa_z),
		.cell_cfg (cell_cfg),
		.out_vld  (back_vld),
		.v_x      (v_x),
		.v_y      (v_y),
		.v_z      (v_z),
		.p2d_x    (pb_x),
		.p2d_y    (pb_y),
		.p2d_z    (pb_z)
	);

	mmi_out #(.COORD_WIDTH(COORD_WIDTH)) u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (back_vld),
		.v_x     (v_x),
		.v_y     (v_y),
		.v_z     (v_z),
		.p2_x    (pb_x),
		.p2_y    (pb_y),
		.p2_z    (pb_z),
		.done    (done),
		.vec_x   (vec_x),
		.vec_y   (vec_y),
		.vec_z   (vec_z),
		.img_x   (img_x),
		.img_y   (img_y),
		.img_z   (img_z),
		.dist_sq (dist_sq)
	);

endmodule

@@ design/mmi_checker.sv @@
// ----------------------------------------------------------------------------
// mmi_checker
// Port-level checks for the minimum image pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module mmi_checker #(
	parameter int COORD_WIDTH = mmi_pkg::COORD_WIDTH_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic signed [COORD_WIDTH-1:0]     p1_x,
	input logic signed [COORD_WIDTH-1:0]     p1_y,
	input logic signed [COORD_WIDTH-1:0]     p1_z,
	input logic signed [COORD_WIDTH-1:0]     p2_x,
	input logic signed [COORD_WIDTH-1:0]     p2_y,
	input logic signed [COORD_WIDTH-1:0]     p2_z,
	input logic                              done,
	input logic signed [COORD_WIDTH-1:0]     vec_x,
	input logic signed [COORD_WIDTH-1:0]     vec_y,
	input logic signed [COORD_WIDTH-1:0]     vec_z,
	input logic signed [COORD_WIDTH-1:0]     img_x,
	input logic signed [COORD_WIDTH-1:0]     img_y,
	input logic signed [COORD_WIDTH-1:0]     img_z,
	input logic [mmi_pkg::DIST_W-1:0]        dist_sq
);
	import mmi_pkg::*;

	// every result matches an earlier start transfer
	property p_done_has_start;
		@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY);
	endproperty
	a_done_has_start: assert property (p_done_has_start)
		else $error("result without matching start transfer");

	// the pipeline never stalls its input
	property p_never_busy;
		@(posedge clk) disable iff (!arst_n)
		start |-> !busy;
	endproperty
	a_never_busy: assert property (p_never_busy)
		else $error("start refused");

	// zero length exactly when the vector is zero
	property p_zero_len;
		@(posedge clk) disable iff (!arst_n)
		done |-> ((dist_sq == '0) == (vec_x == '0 && vec_y == '0 && vec_z == '0));
	endproperty
	a_zero_len: assert property (p_zero_len)
		else $error("squared length disagrees with vector");

	// coincident points give a zero vector and the second point as image
	property p_same_point;
		@(posedge clk) disable iff (!arst_n)
		(done && $past(start && !busy && p1_x == p2_x && p1_y == p2_y
			&& p1_z == p2_z, LATENCY))
		|-> (vec_x == '0 && vec_y == '0 && vec_z == '0
			&& img_x == $past(p2_x, LATENCY) && img_y == $past(p2_y, LATENCY)
			&& img_z == $past(p2_z, LATENCY));
	endproperty
	a_same_point: assert property (p_same_point)
		else $error("coincident points give nonzero vector");

endmodule

bind monoclinic_minimum_image_top mmi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_mmi_checker (.*);
